// File: hdl/tclp_pkg.sv
// Shared types and constants for the text command line parser.
// Used by the classifier, the item queue, the executor and the top level.
`default_nettype none
package tclp_pkg;

  localparam int ID_WIDTH_DEF = 32;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam int CHAR_W       = 8;
  localparam int CMD_ID_W     = 32;
  localparam int SUB_ID_W     = 8;
  localparam int KIND_W       = 3;
  localparam int VALUE_W      = 32;
  localparam int OUT_FIELDS_W = CMD_ID_W + 1 + SUB_ID_W + KIND_W + VALUE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CHR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHR_EMPTY = 8'hFF;
  localparam logic [CHAR_W-1:0] CHR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHR_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CHR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHR_CASE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_LC_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CHR_LC_M  = 8'h6D;
  localparam logic [CHAR_W-1:0] CHR_LC_P  = 8'h70;
  localparam logic [CHAR_W-1:0] CHR_LC_D  = 8'h64;
  localparam logic [CHAR_W-1:0] CHR_LC_I  = 8'h69;
  localparam logic [CHAR_W-1:0] CHR_LC_C  = 8'h63;

  localparam logic [KIND_W-1:0] KIND_TOGGLE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MOVEPOS   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MOVEPOSID = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MOVEPOSIX = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CONFIG    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd7;

  localparam logic [SUB_ID_W-1:0] SUB_ABSENT = 8'hFF;

  typedef enum logic [2:0] {
    CH_OTHER,
    CH_NL,
    CH_EMPTY,
    CH_COLON,
    CH_SEP,
    CH_DIGIT,
    CH_MINUS,
    CH_LETTER
  } char_cls_t;

  typedef struct packed {
    char_cls_t         cls;
    logic [3:0]        digit;
    logic [KIND_W-1:0] kind;
  } tclp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tclp_qstat_t;

endpackage
`default_nettype wire

// File: hdl/tclp_front.sv
// Character classifier: turns one input byte into a class and its payload.
// Depends on tclp_pkg.
`default_nettype none
module tclp_front (
  input  wire logic [tclp_pkg::CHAR_W-1:0] char_in,
  output tclp_pkg::tclp_item_t             item
);
  import tclp_pkg::*;

  logic [CHAR_W-1:0] lower;

  always_comb begin
    lower      = char_in | CHR_CASE;
    item.digit = 4'(char_in - CHR_ZERO);
    if (lower == CHR_LC_T) item.kind = KIND_TOGGLE;
    else if (lower == CHR_LC_M) item.kind = KIND_MOVE;
    else if (lower == CHR_LC_P) item.kind = KIND_MOVEPOS;
    else if (lower == CHR_LC_D) item.kind = KIND_MOVEPOSID;
    else if (lower == CHR_LC_I) item.kind = KIND_MOVEPOSIX;
    else if (lower == CHR_LC_C) item.kind = KIND_CONFIG;
    else item.kind = KIND_NONE;

    if (char_in == CHR_NL) item.cls = CH_NL;
    else if (char_in == CHR_EMPTY) item.cls = CH_EMPTY;
    else if (char_in == CHR_COLON) item.cls = CH_COLON;
    else if (char_in == CHR_SPACE || char_in == CHR_COMMA ||
             char_in == CHR_SEMI || char_in == CHR_SLASH) item.cls = CH_SEP;
    else if (char_in >= CHR_ZERO && char_in <= CHR_NINE) item.cls = CH_DIGIT;
    else if (char_in == CHR_MINUS) item.cls = CH_MINUS;
    else if (item.kind != KIND_NONE) item.cls = CH_LETTER;
    else item.cls = CH_OTHER;
  end

endmodule
`default_nettype wire

// File: hdl/tclp_queue.sv
// Short register queue of classified characters between classifier and executor.
// Depends on tclp_pkg.
`default_nettype none
module tclp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tclp_pkg::tclp_item_t push_item,
  input  wire logic                 pop,
  output tclp_pkg::tclp_item_t      head_item,
  output tclp_pkg::tclp_qstat_t     stat
);
  import tclp_pkg::*;

  tclp_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule
`default_nettype wire

// File: hdl/tclp_back.sv
// Executor: parser state machine, decimal accumulators and the result register.
// Depends on tclp_pkg.
`default_nettype none
module tclp_back #(
  parameter int ID_WIDTH = tclp_pkg::ID_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tclp_pkg::tclp_item_t             head_item,
  input  wire tclp_pkg::tclp_qstat_t            qstat,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [tclp_pkg::CMD_ID_W-1:0]         command_id,
  output logic                                  sub_id_present,
  output logic [tclp_pkg::SUB_ID_W-1:0]         sub_id,
  output logic [tclp_pkg::KIND_W-1:0]           event_kind,
  output logic [tclp_pkg::VALUE_W-1:0]          event_value
);
  import tclp_pkg::*;

  typedef enum logic [2:0] {
    PH_ID,
    PH_ID2,
    PH_TYPE,
    PH_DATA,
    PH_END
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic [SUB_ID_W-1:0] sub_r, sub_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic                neg_r, neg_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CMD_ID_W-1:0] cmd_id_r;
  logic                sub_pres_r;
  logic [SUB_ID_W-1:0] sub_id_r;
  logic [KIND_W-1:0]   kind_out_r;
  logic [VALUE_W-1:0]  value_out_r;

  logic                out_free, is_nl, id_ok, emit;
  logic [63:0]         id_ext;
  logic [SUB_ID_W-1:0] sub_base;

  assign out_free = !out_valid_r || out_ready;
  assign is_nl    = (head_item.cls == CH_NL);
  assign pop      = !qstat.empty && (!is_nl || out_free);
  assign id_ok    = (id_r != '0) && (id_r != '1);
  assign emit     = pop && is_nl && id_ok;
  assign id_ext   = 64'(id_r);
  assign sub_base = (sub_r == SUB_ABSENT) ? '0 : SUB_ID_W'({sub_r, 3'b000} + {sub_r, 1'b0});

  always_comb begin
    phase_nxt     = phase_r;
    id_nxt        = id_r;
    sub_nxt       = sub_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (emit) out_valid_nxt = 1'b1;
    if (pop) begin
      case (head_item.cls)
        CH_NL: begin
          phase_nxt = PH_ID;
          id_nxt    = '0;
          sub_nxt   = SUB_ABSENT;
          kind_nxt  = KIND_NONE;
          val_nxt   = '0;
          neg_nxt   = 1'b0;
        end
        CH_COLON: begin
          if (phase_r == PH_ID) phase_nxt = PH_ID2;
        end
        CH_SEP: begin
          if (phase_r == PH_ID || phase_r == PH_ID2) begin
            phase_nxt = PH_TYPE;
          end else if (phase_r == PH_TYPE) begin
            phase_nxt = PH_DATA;
            val_nxt   = '0;
          end else if (phase_r == PH_DATA) begin
            phase_nxt = PH_END;
          end
        end
        CH_DIGIT: begin
          if (phase_r == PH_ID) begin
            id_nxt  = (id_r << 3) + (id_r << 1) + ID_WIDTH'(head_item.digit);
            val_nxt = '0;
          end else if (phase_r == PH_ID2) begin
            sub_nxt = sub_base + SUB_ID_W'(head_item.digit);
          end else if (phase_r == PH_DATA) begin
            val_nxt = (val_r << 3) + (val_r << 1) + VALUE_W'(head_item.digit);
          end
        end
        CH_MINUS: begin
          if (phase_r == PH_DATA) neg_nxt = 1'b1;
        end
        CH_LETTER: begin
          if (phase_r == PH_TYPE && kind_r == KIND_NONE) kind_nxt = head_item.kind;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ID;
      id_r        <= '0;
      sub_r       <= SUB_ABSENT;
      kind_r      <= KIND_NONE;
      val_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      id_r        <= id_nxt;
      sub_r       <= sub_nxt;
      kind_r      <= kind_nxt;
      val_r       <= val_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      cmd_id_r    <= id_ext[CMD_ID_W-1:0];
      sub_pres_r  <= (sub_r != SUB_ABSENT);
      sub_id_r    <= sub_r;
      kind_out_r  <= (kind_r == KIND_NONE) ? KIND_MOVEPOSID : kind_r;
      value_out_r <= neg_r ? (VALUE_W'(0) - val_r) : val_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign command_id     = cmd_id_r;
  assign sub_id_present = sub_pres_r;
  assign sub_id         = sub_id_r;
  assign event_kind     = kind_out_r;
  assign event_value    = value_out_r;

endmodule
`default_nettype wire

// File: hdl/text_command_line_parser.sv
// Top level of the text command line parser: classifier, queue and executor.
// Depends on tclp_pkg, tclp_front, tclp_queue and tclp_back.
//
// Feed one ASCII byte per word on the in_ stream; lines look like
// "id[:id2] type value" and end in a newline. Space, comma, semicolon and
// slash step through the phases, 0xFF bytes are dropped, a '-' in the value
// phase negates the value, and one letter t/m/p/d/i/c (either case) picks the
// event kind (move position id when no letter is given). On each newline with
// an identifier that is neither zero nor all ones, one result word leaves on
// the out_ stream; the parser then returns to its start state either way.
// The block takes one byte every clock cycle, sustained, unless a newline
// waits on a stalled output. The cycle is set by the executor's
// multiply-by-ten-and-add on the ID_WIDTH-bit identifier accumulator. A
// two-entry queue parts classifier and executor, and a result register parts
// the executor from the output, so only a newline waits on a stalled output;
// other bytes keep flowing while a result is held.
`default_nettype none
module text_command_line_parser #(
  parameter int ID_WIDTH = tclp_pkg::ID_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] char_in
  input  wire logic [tclp_pkg::CHAR_W-1:0]       in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] command_id, [32] sub_id_present, [40:33] sub_id,
  // [43:41] event_kind, [75:44] event_value, [79:76] zero
  output logic [tclp_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import tclp_pkg::*;

  tclp_item_t          cls_item;
  tclp_item_t          head_item;
  tclp_qstat_t         qstat;
  logic                pop;
  logic [CMD_ID_W-1:0] command_id;
  logic                sub_id_present;
  logic [SUB_ID_W-1:0] sub_id;
  logic [KIND_W-1:0]   event_kind;
  logic [VALUE_W-1:0]  event_value;

  // Classify the incoming byte.
  tclp_front u_front (
    .char_in (in_tdata),
    .item    (cls_item)
  );

  // Hold classified bytes until the executor takes them.
  tclp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (cls_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (qstat)
  );

  assign in_tready = !qstat.full;

  // Advance the parser and register results.
  tclp_back #(
    .ID_WIDTH (ID_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_item      (head_item),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .command_id     (command_id),
    .sub_id_present (sub_id_present),
    .sub_id         (sub_id),
    .event_kind     (event_kind),
    .event_value    (event_value)
  );

  // Pack result fields from the lowest bit up; pad with zeros.
  assign out_tdata = OUT_TDATA_W'({event_value, event_kind, sub_id, sub_id_present,
                                   command_id});

  // Queue can never be full and empty at once.
  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  // A newline leaves the queue only when the result register can take it.
  a_nl_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_item.cls == CH_NL) |-> (!out_tvalid || out_tready))
    else $error("newline popped while result register is blocked");

  // Emitted kinds are always a defined event kind.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (event_kind <= KIND_CONFIG))
    else $error("result carries an undefined event kind");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// File: dv/text_command_line_parser_chk.sv
// Scoreboard for the text command line parser: mirrors the line parser,
// queues the commands each newline should produce and checks the out_ stream.
// Depends on tclp_pkg for field widths, character codes and kind codes.
`default_nettype none
module text_command_line_parser_chk (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  // [7:0] char_in
  input  wire logic [tclp_pkg::CHAR_W-1:0]   in_tdata,
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  // [31:0] command_id, [32] sub_id_present, [40:33] sub_id,
  // [43:41] event_kind, [75:44] event_value, [79:76] zero
  input  wire logic [tclp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import tclp_pkg::*;

  localparam int ID_W = ID_WIDTH_DEF;

  typedef enum logic [2:0] {
    PH_ID,
    PH_SUB,
    PH_TYPE,
    PH_VALUE,
    PH_END
  } line_phase_t;

  typedef struct {
    logic [CMD_ID_W-1:0] command_id;
    logic                sub_present;
    logic [SUB_ID_W-1:0] sub_id;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
  } parsed_cmd_t;

  line_phase_t         phase;
  logic [ID_W-1:0]     id_acc;
  logic [SUB_ID_W-1:0] sub_acc;
  logic [KIND_W-1:0]   kind_sel;
  logic [VALUE_W-1:0]  value_acc;
  logic                negative;

  parsed_cmd_t pending_cmds[$];
  int          mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void clear_line();
    phase     = PH_ID;
    id_acc    = '0;
    sub_acc   = SUB_ABSENT;
    kind_sel  = KIND_NONE;
    value_acc = '0;
    negative  = 1'b0;
  endfunction

  // Advance the line state by one character; queue a command on a newline
  // that closes a line with a usable identifier.
  function automatic void parse_char(input logic [CHAR_W-1:0] c);
    logic              is_digit;
    logic [3:0]        d;
    logic [CHAR_W-1:0] folded;
    logic [SUB_ID_W-1:0] base;
    parsed_cmd_t       cmd;
    is_digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
    d        = 4'(c - CHR_ZERO);
    if (c == CHR_NL) begin
      if (id_acc != '0 && id_acc != '1) begin
        cmd.command_id  = id_acc[CMD_ID_W-1:0];
        cmd.sub_present = (sub_acc != SUB_ABSENT);
        cmd.sub_id      = sub_acc;
        cmd.kind        = (kind_sel == KIND_NONE) ? KIND_MOVEPOSID : kind_sel;
        cmd.value       = negative ? (VALUE_W'(0) - value_acc) : value_acc;
        pending_cmds.push_back(cmd);
      end
      clear_line();
    end else if (c == CHR_EMPTY) begin
      // empty byte: nothing changes
    end else if (c == CHR_COLON && phase == PH_ID) begin
      phase = PH_SUB;
    end else if (c == CHR_SPACE || c == CHR_COMMA || c == CHR_SEMI || c == CHR_SLASH) begin
      case (phase)
        PH_ID, PH_SUB: phase = PH_TYPE;
        PH_TYPE: begin
          phase     = PH_VALUE;
          value_acc = '0;
        end
        PH_VALUE: phase = PH_END;
        default: ;
      endcase
    end else begin
      case (phase)
        PH_ID: begin
          if (is_digit) begin
            id_acc    = id_acc * 10 + ID_W'(d);
            value_acc = '0;
          end
        end
        PH_SUB: begin
          if (is_digit) begin
            base    = (sub_acc == SUB_ABSENT) ? 8'd0 : sub_acc * 8'd10;
            sub_acc = base + 8'(d);
          end
        end
        PH_TYPE: begin
          if (kind_sel == KIND_NONE) begin
            folded = c | CHR_CASE;
            case (folded)
              CHR_LC_T: kind_sel = KIND_TOGGLE;
              CHR_LC_M: kind_sel = KIND_MOVE;
              CHR_LC_P: kind_sel = KIND_MOVEPOS;
              CHR_LC_D: kind_sel = KIND_MOVEPOSID;
              CHR_LC_I: kind_sel = KIND_MOVEPOSIX;
              CHR_LC_C: kind_sel = KIND_CONFIG;
              default: ;
            endcase
          end
        end
        PH_VALUE: begin
          if (c == CHR_MINUS) negative = 1'b1;
          if (is_digit) value_acc = value_acc * 10 + VALUE_W'(d);
        end
        default: ;
      endcase
    end
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (mismatches < 10)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    parsed_cmd_t want;
    if (!rst_n) begin
      clear_line();
      pending_cmds.delete();
    end else begin
      if (in_tvalid && in_tready) parse_char(in_tdata);
      if (out_tvalid && out_tready) begin
        if (pending_cmds.size() == 0) begin
          note_mismatch("unexpected result word", 32'h0, out_tdata[31:0]);
        end else begin
          want = pending_cmds.pop_front();
          if (out_tdata[31:0] !== want.command_id)
            note_mismatch("command_id", want.command_id, out_tdata[31:0]);
          if (out_tdata[32] !== want.sub_present)
            note_mismatch("sub_id_present", 32'(want.sub_present), 32'(out_tdata[32]));
          if (out_tdata[40:33] !== want.sub_id)
            note_mismatch("sub_id", 32'(want.sub_id), 32'(out_tdata[40:33]));
          if (out_tdata[43:41] !== want.kind)
            note_mismatch("event_kind", 32'(want.kind), 32'(out_tdata[43:41]));
          if (out_tdata[75:44] !== want.value)
            note_mismatch("event_value", want.value, out_tdata[75:44]);
        end
      end
    end
    fail_count = mismatches;
    pending    = pending_cmds.size();
  end

endmodule
`default_nettype wire

// File: dv/text_command_line_parser_tb.sv
// Top of the parser testbench: clock, reset, character stimulus and output stalls.
// Depends on tclp_pkg, text_command_line_parser and text_command_line_parser_chk.
`default_nettype none
module text_command_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tclp_pkg::*;

  localparam int CHAR_TARGET = 1450;  // non-empty characters to send
  localparam int CALM_FROM   = 1300;  // no idling on either side past this
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [CHAR_W-1:0]      in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int   fail_count;
  int   pending;
  int   chars_sent = 0;
  logic calm = 1'b0;

  // 10 ns period, low half first.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_command_line_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  text_command_line_parser_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: hold out_tready low for random bursts, otherwise keep it
  // high. No stalls once the run goes calm.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end else if (rst_n && !calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one character and hold it until the parser takes it. A random
  // gap with tvalid low may come first.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    if (c != CHR_EMPTY) chars_sent++;
    if (chars_sent >= CALM_FROM) calm = 1'b1;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(8'(s[i]));
  endtask

  function automatic logic [CHAR_W-1:0] any_digit();
    return CHR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] any_sep();
    case ($urandom_range(0, 3))
      0: return CHR_SPACE;
      1: return CHR_COMMA;
      2: return CHR_SEMI;
      default: return CHR_SLASH;
    endcase
  endfunction

  // Pick one of the six kind letters, upper or lower case.
  function automatic logic [CHAR_W-1:0] any_kind_letter();
    logic [CHAR_W-1:0] l;
    case ($urandom_range(0, 5))
      0: l = CHR_LC_T;
      1: l = CHR_LC_M;
      2: l = CHR_LC_P;
      3: l = CHR_LC_D;
      4: l = CHR_LC_I;
      default: l = CHR_LC_C;
    endcase
    return $urandom_range(0, 1) ? l : (l & ~CHR_CASE);
  endfunction

  // Build one command line: mostly well formed with random content, some
  // broken forms (stray colons, junk, wrapping numbers, bad identifiers),
  // and now and then pure noise. The newline is always appended.
  task automatic build_line(ref logic [CHAR_W-1:0] line[$]);
    int    n;
    string s;
    line.delete();
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 12)) line.push_back(8'($urandom_range(0, 255)));
    end else begin
      // identifier: zero, all ones, a wrapping run of digits, or a short number
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) line.push_back(CHR_ZERO);
        1: begin
          s = "4294967295";
          for (int i = 0; i < s.len(); i++) line.push_back(8'(s[i]));
        end
        2: repeat ($urandom_range(10, 14)) line.push_back(any_digit());
        default: repeat ($urandom_range(1, 4)) line.push_back(any_digit());
      endcase
      if ($urandom_range(0, 2) == 0) begin
        line.push_back(CHR_COLON);
        case ($urandom_range(0, 5))
          0: begin
            s = "255";
            for (int i = 0; i < s.len(); i++) line.push_back(8'(s[i]));
          end
          1: repeat ($urandom_range(4, 6)) line.push_back(any_digit());
          2: ;
          default: repeat ($urandom_range(1, 3)) line.push_back(any_digit());
        endcase
      end
      line.push_back(any_sep());
      if ($urandom_range(0, 9) == 0) line.push_back(CHR_COLON);
      if ($urandom_range(0, 7) == 0) line.push_back(8'($urandom_range(8'h41, 8'h7A)));
      if ($urandom_range(0, 7) != 0) line.push_back(any_kind_letter());
      if ($urandom_range(0, 4) == 0) line.push_back(any_kind_letter());
      if ($urandom_range(0, 7) != 0) begin
        line.push_back(any_sep());
        if ($urandom_range(0, 2) == 0) line.push_back(CHR_MINUS);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 5);
        repeat (n) line.push_back(any_digit());
        if ($urandom_range(0, 9) == 0) line.push_back(CHR_MINUS);
        if ($urandom_range(0, 4) == 0) begin
          // junk after the value: separators, colons, digits and kind letters, all dropped
          line.push_back(any_sep());
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0: line.push_back(any_sep());
              1: line.push_back(CHR_COLON);
              2: line.push_back(any_digit());
              default: line.push_back(any_kind_letter());
            endcase
          end
        end
      end
    end
    line.push_back(CHR_NL);
  endtask

  initial begin
    logic [CHAR_W-1:0] line[$];
    logic [CHAR_W-1:0] c;

    // Hold reset, then release on a rising edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, the empty byte, a zero identifier (dropped),
    // a line with no kind letter, a full line with sub id, upper-case kind
    // and negative value, and an all-ones identifier (dropped).
    send_char(8'h00);
    send_char(CHR_EMPTY);
    send_char(CHR_NL);
    send_text("7\n");
    send_text("9:3,M;-12\n");
    send_text("4294967295\n");

    // Random lines, with empty bytes and stray characters sprinkled in.
    while (chars_sent < CHAR_TARGET) begin
      build_line(line);
      foreach (line[i]) begin
        if ($urandom_range(0, 11) == 0) send_char(CHR_EMPTY);
        if ($urandom_range(0, 39) == 0) begin
          c = 8'($urandom_range(0, 255));
          send_char(c);
        end
        send_char(line[i]);
      end
    end

    // Drain: drop tvalid, wait out the last results, then a few more cycles.
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
